// ===== rtl/pedt_pkg.sv =====
// Shared types and constants for the pausable event duration timers.
package pedt_pkg;

  localparam int TIME_W     = 48;
  localparam int ID_W       = 4;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int TIMERS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_START  = 2'd0,
    OP_END    = 2'd1,
    OP_PAUSE  = 2'd2,
    OP_RESUME = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_NO_EFFECT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_END_SUB,
    S_END_PAUSED,
    S_SPAN,
    S_SW_READ,
    S_SW_CMP,
    S_SW_ADD,
    S_RESP
  } state_t;

endpackage

// ===== rtl/pedt_alu.sv =====
// Shared 48-bit add/subtract unit with carry out (borrow-free flag on subtract).
module pedt_alu
  import pedt_pkg::*;
(
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  input  logic              sub,
  output logic [TIME_W-1:0] res,
  output logic              carry
);

  logic [TIME_W:0] sum;

  // sub: a + ~b + 1, carry set when a >= b; add: carry set on overflow
  assign sum   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{TIME_W{1'b0}}, sub};
  assign res   = sum[TIME_W-1:0];
  assign carry = sum[TIME_W];

endmodule

// ===== rtl/pausable_event_duration_timers.sv =====
// Top level: stopwatch table with global pause, sequenced around one shared adder.
// Sequence: start, pause, failed ops and resume while not paused go straight to
// S_RESP; a good end passes S_END_SUB and S_END_PAUSED; a resume runs S_SPAN,
// then S_SW_READ, S_SW_CMP per slot and S_SW_ADD per live slot (timer RAM sweep).
// busy stays high through the result beat, so a new request waits until it ends.
// Synchronous reset frees all slots and clears the pause; timer RAMs are not cleared.
module pausable_event_duration_timers
  import pedt_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     req_type,
  input  logic [ID_W-1:0]     timer_id,
  input  logic [TIME_W-1:0]   now_ms,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [TIME_W-1:0]   duration_ms,
  output logic                paused_now
);

  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W = $clog2(TIMERS + 1);
  localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  state_t state, state_next;

  logic [TIMERS-1:0]  slot_live;
  logic               pause_active;
  logic [TIME_W-1:0]  pause_began;

  logic [IDX_W-1:0]   idx_q;
  logic [TIME_W-1:0]  now_q;
  logic [IDX_W-1:0]   cnt;
  logic [TIME_W-1:0]  acc;
  logic               flag;
  status_t            status_q;
  logic [TIME_W-1:0]  dur_q;

  logic [TIME_W-1:0]  start_mem [TIMERS];
  logic [TIME_W-1:0]  total_mem [TIMERS];
  logic [TIME_W-1:0]  start_rd;
  logic [TIME_W-1:0]  total_rd;

  op_t                op_in;
  logic [IDX_W-1:0]   idx_in;
  logic               valid_in;
  logic               accept;
  logic               cnt_last;
  logic [IDX_W-1:0]   mem_addr;
  logic               start_we;
  logic               total_we;
  logic [TIME_W-1:0]  total_wd;

  logic [TIME_W-1:0]  alu_a;
  logic [TIME_W-1:0]  alu_b;
  logic               alu_sub;
  logic [TIME_W-1:0]  alu_res;
  logic               alu_carry;

  pedt_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_carry)
  );

  assign op_in    = op_t'(req_type);
  assign idx_in   = IDX_W'(timer_id);
  assign valid_in = CMP_W'(timer_id) < CMP_W'(TIMERS);
  assign accept   = start && (state == S_IDLE);
  assign cnt_last = (cnt == IDX_W'(TIMERS - 1));

  assign busy        = (state != S_IDLE);
  assign done        = (state == S_RESP);
  assign status      = status_q;
  assign duration_ms = dur_q;
  assign paused_now  = pause_active;

  // next state, adder operand selection, RAM port control
  always_comb begin
    state_next = state;
    alu_a      = now_q;
    alu_b      = start_rd;
    alu_sub    = 1'b1;
    mem_addr   = idx_q;
    start_we   = 1'b0;
    total_we   = 1'b0;
    total_wd   = '0;
    case (state)
      S_IDLE: begin
        mem_addr = idx_in;
        if (start) begin
          case (op_in)
            OP_START: begin
              if (valid_in && !slot_live[idx_in]) begin
                start_we = 1'b1;
                total_we = 1'b1;
              end
              state_next = S_RESP;
            end
            OP_END: begin
              if (valid_in && slot_live[idx_in]) state_next = S_END_SUB;
              else state_next = S_RESP;
            end
            OP_PAUSE: state_next = S_RESP;
            OP_RESUME: begin
              if (pause_active) state_next = S_SPAN;
              else state_next = S_RESP;
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_END_SUB: begin
        alu_a      = now_q;
        alu_b      = start_rd;
        state_next = S_END_PAUSED;
      end
      S_END_PAUSED: begin
        alu_a      = acc;
        alu_b      = total_rd;
        state_next = S_RESP;
      end
      S_SPAN: begin
        alu_a      = now_q;
        alu_b      = pause_began;
        mem_addr   = cnt;
        state_next = S_SW_READ;
      end
      S_SW_READ: begin
        mem_addr   = cnt;
        state_next = S_SW_CMP;
      end
      S_SW_CMP: begin
        alu_a    = pause_began;
        alu_b    = start_rd;
        mem_addr = cnt;
        if (slot_live[cnt]) state_next = S_SW_ADD;
        else if (cnt_last) state_next = S_RESP;
        else state_next = S_SW_READ;
      end
      S_SW_ADD: begin
        alu_a    = total_rd;
        alu_b    = acc;
        alu_sub  = 1'b0;
        mem_addr = cnt;
        total_we = flag;
        total_wd = alu_carry ? TIME_MAX : alu_res;
        if (cnt_last) state_next = S_RESP;
        else state_next = S_SW_READ;
      end
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // timer RAMs, registered read
  always_ff @(posedge clk) begin
    if (start_we) start_mem[mem_addr] <= now_ms;
    if (total_we) total_mem[mem_addr] <= total_wd;
    start_rd <= start_mem[mem_addr];
    total_rd <= total_mem[mem_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_live    <= '0;
      pause_active <= 1'b0;
    end else begin
      if (start_we) slot_live[idx_in] <= 1'b1;
      if (state == S_END_PAUSED) slot_live[idx_q] <= 1'b0;
      if (accept && op_in == OP_PAUSE) pause_active <= 1'b1;
      if (state_next == S_RESP && (state == S_SW_CMP || state == S_SW_ADD))
        pause_active <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_q <= idx_in;
      now_q <= now_ms;
      cnt   <= '0;
      dur_q <= '0;
      case (op_in)
        OP_START:  status_q <= (valid_in && !slot_live[idx_in]) ? ST_DONE : ST_NO_EFFECT;
        OP_END:    status_q <= (valid_in && slot_live[idx_in]) ? ST_DONE : ST_UNKNOWN;
        OP_PAUSE:  status_q <= pause_active ? ST_NO_EFFECT : ST_DONE;
        OP_RESUME: status_q <= pause_active ? ST_DONE : ST_NO_EFFECT;
        default:   status_q <= ST_NO_EFFECT;
      endcase
      if (op_in == OP_PAUSE && !pause_active) pause_began <= now_ms;
    end
    case (state)
      S_END_SUB: begin
        acc  <= alu_res;
        flag <= alu_carry;
      end
      S_END_PAUSED: dur_q <= (flag && alu_carry) ? alu_res : '0;
      // span clamps to zero when time ran backwards
      S_SPAN: acc <= alu_carry ? alu_res : '0;
      S_SW_CMP: begin
        flag <= alu_carry;
        if (!slot_live[cnt] && !cnt_last) cnt <= cnt + 1'b1;
      end
      S_SW_ADD: begin
        if (!cnt_last) cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule
